[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/mcos_pkg.sv]
package mcos_pkg;

	// operand and accumulator widths
	localparam int ANGLE_W = 32;
	localparam int X2_W    = 35;
	localparam int TERM_W  = 43;
	localparam int SUM_W   = 44;
	localparam int A_W     = 44;
	localparam int CHUNK_W = 18;
	localparam int B_W     = 2 * CHUNK_W;
	localparam int P_W     = A_W + CHUNK_W;
	localparam int ACC_W   = A_W + B_W;
	localparam int CNT_W   = 5;
	localparam int FRAC_W  = 28;
	localparam int RCP_W   = 32;

	// term limit (unsigned Q15.28) and sum limits (signed Q16.28)
	localparam logic [TERM_W-1:0] TERM_MAX = '1;
	localparam logic signed [SUM_W+1:0] SUM_HI = 46'sd8796093022207;
	localparam logic signed [SUM_W+1:0] SUM_LO = -46'sd8796093022208;

	// multiply operations
	localparam logic [1:0] OP_SQ = 2'd0;	// x * x
	localparam logic [1:0] OP_F  = 2'd1;	// x^2 * recip
	localparam logic [1:0] OP_T  = 2'd2;	// term * factor

	// controller to datapath command
	typedef struct packed {
		logic             load;
		logic             mul_hi;
		logic             acc_first;
		logic             acc_add;
		logic             wb;
		logic             add_term;
		logic             out_load;
		logic             neg;
		logic [1:0]       op;
		logic [CNT_W-1:0] k;
	} mcos_cmd_t;

	// round(2^32 / ((2k-1)(2k))), Q.32
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] k);
		logic [RCP_W-1:0] r;
		case (k)
			5'd1:    r = 32'd2147483648;
			5'd2:    r = 32'd357913941;
			5'd3:    r = 32'd143165577;
			5'd4:    r = 32'd76695845;
			5'd5:    r = 32'd47721859;
			5'd6:    r = 32'd32537631;
			5'd7:    r = 32'd23598721;
			5'd8:    r = 32'd17895697;
			5'd9:    r = 32'd14035841;
			5'd10:   r = 32'd11302546;
			5'd11:   r = 32'd9296466;
			5'd12:   r = 32'd7780738;
			5'd13:   r = 32'd6607642;
			5'd14:   r = 32'd5681174;
			5'd15:   r = 32'd4936744;
			5'd16:   r = 32'd4329604;
			5'd17:   r = 32'd3827957;
			5'd18:   r = 32'd3408704;
			5'd19:   r = 32'd3054742;
			5'd20:   r = 32'd2753184;
			5'd21:   r = 32'd2494174;
			5'd22:   r = 32'd2270067;
			5'd23:   r = 32'd2074863;
			5'd24:   r = 32'd1903798;
			5'd25:   r = 32'd1753048;
			5'd26:   r = 32'd1619520;
			5'd27:   r = 32'd1500687;
			5'd28:   r = 32'd1394470;
			5'd29:   r = 32'd1299143;
			5'd30:   r = 32'd1213268;
			5'd31:   r = 32'd1135634;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/mcos_datapath.sv]
module mcos_datapath import mcos_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mcos_cmd_t                cmd,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic signed [SUM_W-1:0]  cosine,
	output logic                     saturated
);

	logic [ANGLE_W-1:0]      mag_q;
	logic [X2_W-1:0]         x2_q;
	logic [X2_W-1:0]         f_q;
	logic [TERM_W-1:0]       term_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    sat_q;
	logic signed [SUM_W-1:0] cosine_q;
	logic                    saturated_q;

	logic [A_W-1:0]          a_op;
	logic [B_W-1:0]          b_op;
	logic [CHUNK_W-1:0]      chunk;
	logic [P_W-1:0]          prod_s1;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        acc_r28;
	logic [ACC_W-1:0]        acc_r32;
	logic [ACC_W-FRAC_W-1:0] t_full;
	logic signed [SUM_W+1:0] sum_ext;
	logic signed [SUM_W+1:0] term_ext;
	logic signed [SUM_W+1:0] sum_nx;

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.op)
			OP_SQ: begin
				a_op = A_W'(mag_q);
				b_op = B_W'(mag_q);
			end
			OP_F: begin
				a_op = A_W'(x2_q);
				b_op = B_W'(recip(cmd.k));
			end
			default: begin
				a_op = A_W'(term_q);
				b_op = B_W'(f_q);
			end
		endcase
		chunk = cmd.mul_hi ? b_op[B_W-1:CHUNK_W] : b_op[CHUNK_W-1:0];
	end

	// rounding and signed sum update
	always_comb begin
		acc_r28  = acc_q + (ACC_W'(1) << (FRAC_W - 1));
		acc_r32  = acc_q + (ACC_W'(1) << (RCP_W - 1));
		t_full   = acc_r28[ACC_W-1:FRAC_W];
		sum_ext  = {{2{sum_q[SUM_W-1]}}, sum_q};
		term_ext = {3'b000, term_q};
		sum_nx   = cmd.neg ? (sum_ext - term_ext) : (sum_ext + term_ext);
	end

	// product register and two-chunk accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= a_op * chunk;
		if (cmd.acc_first) begin
			acc_q <= ACC_W'(prod_s1);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + (ACC_W'(prod_s1) << CHUNK_W);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
			term_q <= TERM_W'(1) << FRAC_W;
			sum_q  <= '0;
			sat_q  <= 1'b0;
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_SQ: x2_q <= t_full[X2_W-1:0];
				OP_F:  f_q  <= acc_r32[RCP_W+X2_W-1:RCP_W];
				default: begin
					if (t_full > {{(ACC_W-FRAC_W-TERM_W){1'b0}}, TERM_MAX}) begin
						term_q <= TERM_MAX;
						sat_q  <= 1'b1;
					end else begin
						term_q <= t_full[TERM_W-1:0];
					end
				end
			endcase
		end
		if (cmd.add_term) begin
			if (sum_nx > SUM_HI) begin
				sum_q <= SUM_HI[SUM_W-1:0];
				sat_q <= 1'b1;
			end else if (sum_nx < SUM_LO) begin
				sum_q <= SUM_LO[SUM_W-1:0];
				sat_q <= 1'b1;
			end else begin
				sum_q <= sum_nx[SUM_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cosine_q    <= '0;
			saturated_q <= 1'b0;
		end else if (cmd.out_load) begin
			cosine_q    <= sum_q;
			saturated_q <= sat_q;
		end
	end

	assign cosine    = cosine_q;
	assign saturated = saturated_q;

endmodule

[rtl/core/mcos_ctrl.sv]
module mcos_ctrl import mcos_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] term_count,
	output mcos_cmd_t        cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_M0   = 3'd1;
	localparam logic [2:0] S_M1   = 3'd2;
	localparam logic [2:0] S_M2   = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_ADD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic [CNT_W:0] LIMIT = (CNT_W+1)'(MAX_TERMS);

	logic [2:0]       state_q;
	logic [1:0]       op_q;
	logic [CNT_W-1:0] term_count_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_in;
	logic             more;
	logic             out_free;

	// term count clamp and loop test
	always_comb begin
		count_in = ({1'b0, term_count_q} > LIMIT) ? LIMIT[CNT_W-1:0] : term_count_q;
		more     = ({1'b0, n_q} + 1'b1) < {1'b0, count_q};
		out_free = !out_valid_q || out_ready;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_SQ;
			term_count_q <= CNT_W'(8);
			count_q      <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				term_count_q <= term_count;
			end
			// DONE reloads the output register itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						count_q <= count_in;
						n_q     <= '0;
						op_q    <= OP_SQ;
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_WB;
				S_WB: begin
					case (op_q)
						OP_SQ: state_q <= (count_q == '0) ? S_DONE : S_ADD;
						OP_F: begin
							op_q    <= OP_T;
							state_q <= S_M0;
						end
						default: begin
							n_q     <= n_q + 1'b1;
							state_q <= S_ADD;
						end
					endcase
				end
				S_ADD: begin
					if (more) begin
						op_q    <= OP_F;
						state_q <= S_M0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.mul_hi    = (state_q == S_M1);
		cmd.acc_first = (state_q == S_M1);
		cmd.acc_add   = (state_q == S_M2);
		cmd.wb        = (state_q == S_WB);
		cmd.add_term  = (state_q == S_ADD);
		cmd.out_load  = (state_q == S_DONE) && out_free;
		cmd.neg       = n_q[0];
		cmd.op        = op_q;
		cmd.k         = n_q + 1'b1;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule

[rtl/core/maclaurin_cosine.sv]
// Cosine by truncated Maclaurin series.
// Input channel (in_valid/in_ready, angle): one request is an angle in radians,
// signed Q4.28. Output channel (out_valid/out_ready, cosine, saturated): one
// request per angle, the series sum in signed Q16.28 and a flag that is set
// when a term or a partial sum was clamped.
// Config channel (cfg_valid/cfg_ready, term_count): number of terms, reset 8,
// clamped to MAX_TERMS; zero terms gives cosine 0. cfg_ready is always high.
// One angle is worked on at a time. Each product goes through one shared
// 44x18 multiplier in two chunks (states M0, M1 and M2, rounded in WB), and
// each term after the first needs two products. in_ready rises in the cycle
// the result shows, so a new angle is taken only after the last is done.
// The result sits in an output register: a new angle is taken while it waits,
// but the next result waits in the DONE state until the receiver takes it.
// Reset (arst_n low) drops out_valid, empties the block and sets
// term_count back to 8.
module maclaurin_cosine import mcos_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SUM_W-1:0]   cosine,
	output logic                      saturated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CNT_W-1:0]          term_count
);

	mcos_cmd_t cmd;

	// sequencer
	mcos_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.term_count(term_count),
		.cmd       (cmd)
	);

	// multiplier, accumulator and series registers
	mcos_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.angle    (angle),
		.cosine   (cosine),
		.saturated(saturated)
	);

endmodule

[rtl/core/mcos_checker.sv]
`include "assert_macros.svh"

module mcos_checker import mcos_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [SUM_W-1:0]   cosine,
	input logic                      saturated,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cosine) && $stable(saturated))

	// one angle in flight: input closes right after a request
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result appears only as the working angle finishes
	`ASSERT_IMPL(a_result_from_work, clk, arst_n, $rose(out_valid), !$past(in_ready) && in_ready)

	// config is always taken
	`ASSERT_IMPL(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind maclaurin_cosine mcos_checker u_mcos_checker (.*);
